// ===== rtl/whcp_pkg.sv =====
// ----------------------------------------------------------------------------
// whcp_pkg
// Shared tags, status codes and item types of the RIFF/WAVE header parser.
// ----------------------------------------------------------------------------
`default_nettype none

package whcp_pkg;

  // four-character tags as they assemble little-endian
  localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
  localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
  localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
  localparam logic [31:0] TAG_DATA = 32'h6174_6164;

  // fixed part of the fmt chunk body
  localparam logic [31:0] FMT_BODY      = 32'd16;
  localparam logic [15:0] PCM_FORMAT    = 16'd1;
  localparam logic [15:0] BITS_REQUIRED = 16'd16;

  typedef enum logic [2:0] {
    STAT_OK         = 3'd0,
    STAT_BAD_MAGIC  = 3'd1,
    STAT_NOT_PCM    = 3'd2,
    STAT_TRUNCATED  = 3'd3,
    STAT_BAD_PARAMS = 3'd4
  } status_t;

  // one input item
  typedef struct packed {
    logic [7:0] stream_byte;
    logic       end_of_stream;
  } in_item_t;

  // one result item
  typedef struct packed {
    status_t     status;
    logic [15:0] channels;
    logic [31:0] sample_rate;
    logic [31:0] data_size;
    logic [31:0] data_offset;
  } result_t;

endpackage

`default_nettype wire

// ===== rtl/whcp_if.sv =====
// ----------------------------------------------------------------------------
// whcp_if
// Valid/ready channels for the byte stream and for the header verdict.
// ----------------------------------------------------------------------------
`default_nettype none

interface whcp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] stream_byte;
  logic       end_of_stream;

  modport source (output valid, output stream_byte, output end_of_stream, input ready);
  modport sink   (input valid, input stream_byte, input end_of_stream, output ready);
endinterface

interface whcp_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [15:0] channels;
  logic [31:0] sample_rate;
  logic [31:0] data_size;
  logic [31:0] data_offset;

  modport source (output valid, output status, output channels, output sample_rate,
                  output data_size, output data_offset, input ready);
  modport sink   (input valid, input status, input channels, input sample_rate,
                  input data_size, input data_offset, output ready);
endinterface

`default_nettype wire

// ===== rtl/whcp_in_stage.sv =====
// ----------------------------------------------------------------------------
// whcp_in_stage
// Input register: holds one byte item until the parser takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module whcp_in_stage (
  input  logic               clk,
  input  logic               rst_n,
  whcp_in_if.sink            in_chan,
  output logic               item_valid,
  output whcp_pkg::in_item_t item,
  input  logic               item_take
);
  import whcp_pkg::*;

  logic     valid_r;
  in_item_t item_r;
  logic     in_fire;

  // room when empty or when the held item leaves this cycle
  assign in_chan.ready = !valid_r || item_take;
  assign in_fire       = in_chan.valid && in_chan.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_fire) begin
      valid_r <= 1'b1;
    end else if (item_take) begin
      valid_r <= 1'b0;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      item_r.stream_byte   <= in_chan.stream_byte;
      item_r.end_of_stream <= in_chan.end_of_stream;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

`default_nettype wire

// ===== rtl/whcp_parse.sv =====
// ----------------------------------------------------------------------------
// whcp_parse
// Header walk, one byte per cycle unless stalled, and the registered verdict.
// ----------------------------------------------------------------------------
`default_nettype none

module whcp_parse (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               item_valid,
  input  whcp_pkg::in_item_t item,
  output logic               item_take,
  whcp_out_if.source         out_chan
);
  import whcp_pkg::*;

  typedef enum logic [2:0] {
    PH_RIFF  = 3'd0,
    PH_RSIZE = 3'd1,
    PH_WAVE  = 3'd2,
    PH_ID    = 3'd3,
    PH_SIZE  = 3'd4,
    PH_FMT   = 3'd5,
    PH_SKIP  = 3'd6
  } phase_t;

  typedef struct packed {
    phase_t      phase;
    logic [3:0]  fbc;
    logic [31:0] shift;
    logic [31:0] tag;
    logic [31:0] len;
    logic [31:0] skip;
    logic [31:0] pos;
    logic [15:0] chans;
    logic [31:0] rate;
    logic [15:0] bits;
    logic        verdict;
    logic        magic_bad;
  } pstate_t;

  localparam pstate_t ST_RESET = '{
    phase: PH_RIFF, fbc: 4'd0, shift: 32'd0, tag: 32'd0, len: 32'd0, skip: 32'd0,
    pos: 32'd0, chans: 16'd0, rate: 32'd0, bits: 16'd0, verdict: 1'b0, magic_bad: 1'b0
  };

  pstate_t     st_r;
  pstate_t     st_nxt;
  result_t     res_r;
  result_t     res;
  logic        res_valid;
  logic        out_valid_r;
  logic        out_valid_nxt;

  logic [31:0] shift_new;
  logic [3:0]  fbc_inc;
  logic        word_done;
  logic [31:0] pad_len;
  logic [31:0] skip_dec;
  logic        fmt_extra;
  logic        hit;
  status_t     hit_status;
  logic        hit_data;
  logic        data_ok;

  // the parser moves when the result register can take what it makes
  assign item_take = item_valid && (!out_valid_r || out_chan.ready);

  assign shift_new = {item.stream_byte, st_r.shift[31:8]};
  assign fbc_inc   = st_r.fbc + 4'd1;
  assign word_done = fbc_inc >= 4'd4;
  assign pad_len   = (shift_new + 32'd1) & ~32'd1;
  assign skip_dec  = st_r.skip - 32'd1;
  assign fmt_extra = st_r.len > FMT_BODY;
  assign data_ok   = (st_r.chans != 16'd0) && (st_r.rate != 32'd0) &&
                     (shift_new != 32'd0) && (st_r.bits == BITS_REQUIRED);

  // next state and verdict for the held byte
  always_comb begin
    st_nxt     = st_r;
    hit        = 1'b0;
    hit_status = STAT_OK;
    hit_data   = 1'b0;

    if (!st_r.verdict) begin
      st_nxt.pos   = st_r.pos + 32'd1;
      st_nxt.shift = shift_new;

      case (st_r.phase)
        PH_RIFF: begin
          st_nxt.fbc = word_done ? 4'd0 : fbc_inc;
          if (word_done) begin
            st_nxt.magic_bad = shift_new != TAG_RIFF;
            st_nxt.phase     = PH_RSIZE;
          end
        end
        PH_RSIZE: begin
          st_nxt.fbc = word_done ? 4'd0 : fbc_inc;
          if (word_done) begin
            st_nxt.phase = PH_WAVE;
          end
        end
        PH_WAVE: begin
          st_nxt.fbc = word_done ? 4'd0 : fbc_inc;
          if (word_done) begin
            if (st_r.magic_bad || shift_new != TAG_WAVE) begin
              hit        = 1'b1;
              hit_status = STAT_BAD_MAGIC;
            end else begin
              st_nxt.phase = PH_ID;
            end
          end
        end
        PH_ID: begin
          st_nxt.fbc = word_done ? 4'd0 : fbc_inc;
          if (word_done) begin
            st_nxt.tag   = shift_new;
            st_nxt.phase = PH_SIZE;
          end
        end
        PH_SIZE: begin
          st_nxt.fbc = word_done ? 4'd0 : fbc_inc;
          if (word_done) begin
            st_nxt.len = shift_new;
            if (st_r.tag == TAG_FMT) begin
              st_nxt.phase = PH_FMT;
            end else if (st_r.tag == TAG_DATA) begin
              hit        = 1'b1;
              hit_data   = 1'b1;
              hit_status = data_ok ? STAT_OK : STAT_BAD_PARAMS;
            end else begin
              st_nxt.skip  = pad_len;
              st_nxt.phase = (pad_len != 32'd0) ? PH_SKIP : PH_ID;
            end
          end
        end
        PH_FMT: begin
          st_nxt.fbc = fbc_inc;
          case (st_r.fbc)
            4'd1: begin
              if (shift_new[31:16] != PCM_FORMAT) begin
                hit        = 1'b1;
                hit_status = STAT_NOT_PCM;
              end
            end
            4'd3: begin
              st_nxt.chans = shift_new[31:16];
            end
            4'd7: begin
              st_nxt.rate = shift_new;
            end
            4'd15: begin
              st_nxt.bits  = shift_new[31:16];
              st_nxt.fbc   = 4'd0;
              st_nxt.skip  = fmt_extra ? (st_r.len - FMT_BODY) : 32'd0;
              st_nxt.phase = fmt_extra ? PH_SKIP : PH_ID;
            end
            default: begin
            end
          endcase
        end
        PH_SKIP: begin
          st_nxt.skip = skip_dec;
          if (skip_dec == 32'd0) begin
            st_nxt.fbc   = 4'd0;
            st_nxt.phase = PH_ID;
          end
        end
        default: begin
          st_nxt.phase = PH_RIFF;
          st_nxt.fbc   = 4'd0;
        end
      endcase

      if (hit) begin
        st_nxt.verdict = 1'b1;
      end
    end
  end

  // result item: a verdict, or truncated on a last byte without one
  always_comb begin
    res_valid       = !st_r.verdict && (hit || item.end_of_stream);
    res.status      = hit ? hit_status : STAT_TRUNCATED;
    res.channels    = st_nxt.chans;
    res.sample_rate = st_nxt.rate;
    res.data_size   = hit_data ? st_nxt.len : 32'd0;
    res.data_offset = hit_data ? st_nxt.pos : 32'd0;
  end

  assign out_valid_nxt = item_take ? res_valid : (out_valid_r && !out_chan.ready);

  // state and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_RESET;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (item_take) begin
        st_r <= item.end_of_stream ? ST_RESET : st_nxt;
        if (res_valid) begin
          res_r <= res;
        end
      end
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.status      = res_r.status;
  assign out_chan.channels    = res_r.channels;
  assign out_chan.sample_rate = res_r.sample_rate;
  assign out_chan.data_size   = res_r.data_size;
  assign out_chan.data_offset = res_r.data_offset;

endmodule

`default_nettype wire

// ===== rtl/wav_header_chunk_parser.sv =====
// ----------------------------------------------------------------------------
// wav_header_chunk_parser
// RIFF/WAVE header parser: checks the magic, walks the chunks and gives one
// verdict on the data chunk.
// ----------------------------------------------------------------------------
// Usage:
//   in_chan takes the file one byte per item, in file order, with
//   end_of_stream set on the final byte. out_chan gives at most one verdict
//   item per file: status, channels, sample rate and, for a data chunk,
//   its size and the offset where PCM data starts.
//   Bytes after a verdict are swallowed until the final byte, which rearms
//   the parser; a final byte with no verdict yields a truncated status.
//   Path of a result item: its byte lands in the input register when
//   accepted, and the single-pass state update then loads the result
//   register when the parser takes the byte.
//   Throughput: one byte per cycle unless the receiver stalls.
//   Reset clears the walk state; the parser then expects the RIFF tag.
//   When the receiver stalls, one more byte is taken into the input
//   register, then in_chan.ready drops until the result item is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module wav_header_chunk_parser (
  input  logic       clk,
  input  logic       rst_n,
  whcp_in_if.sink    in_chan,
  whcp_out_if.source out_chan
);
  import whcp_pkg::*;

  logic     item_valid;
  in_item_t item;
  logic     item_take;

  // input register
  whcp_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_chan    (in_chan),
    .item_valid (item_valid),
    .item       (item),
    .item_take  (item_take)
  );

  // header walk and verdict register
  whcp_parse u_parse (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item_valid),
    .item       (item),
    .item_take  (item_take),
    .out_chan   (out_chan)
  );

endmodule

`default_nettype wire

// ===== rtl/whcp_checker.sv =====
// ----------------------------------------------------------------------------
// whcp_checker
// Port-level checks of the header parser, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module whcp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  out_status,
  input logic [15:0] out_channels,
  input logic [31:0] out_sample_rate,
  input logic [31:0] out_data_size,
  input logic [31:0] out_data_offset
);
  import whcp_pkg::*;

  // nothing comes out right after reset
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result item valid after reset");

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) &&
    $stable(out_data_size) && $stable(out_data_offset))
    else $error("stalled result item changed");

  // ok verdict only with usable parameters
  a_ok_params: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == STAT_OK |->
    out_channels != 16'd0 && out_sample_rate != 32'd0 && out_data_size != 32'd0)
    else $error("ok verdict with zero parameter");

  // data fields only on a data chunk verdict
  a_no_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != STAT_OK && out_status != STAT_BAD_PARAMS |->
    out_data_size == 32'd0 && out_data_offset == 32'd0)
    else $error("data fields set without a data chunk");

  // input register holds one byte while the output is stalled
  a_one_ahead: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready && in_valid && in_ready |=> in_ready == out_ready)
    else $error("input taken beyond the input register");

endmodule

bind wav_header_chunk_parser whcp_checker u_whcp_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_chan.valid),
  .in_ready        (in_chan.ready),
  .out_valid       (out_chan.valid),
  .out_ready       (out_chan.ready),
  .out_status      (out_chan.status),
  .out_channels    (out_chan.channels),
  .out_sample_rate (out_chan.sample_rate),
  .out_data_size   (out_chan.data_size),
  .out_data_offset (out_chan.data_offset)
);

`default_nettype wire

// ===== verif/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Checks wav_header_chunk_parser by feeding whole WAV files byte by byte,
// well-formed and broken ones, and comparing every verdict item against a
// byte-level model of the header walk kept inside this bench.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import whcp_pkg::*;

  localparam int STALL_LIMIT = 4000;
  localparam int HOLD_CYCLES = 400;

  // walk phases of the header model
  typedef enum logic [2:0] {
    W_RIFF, W_RSIZE, W_WAVE, W_ID, W_SIZE, W_FMT, W_SKIP
  } walk_t;

  logic clk;
  logic rst_n;

  whcp_in_if  in_chan ();
  whcp_out_if out_chan ();

  wav_header_chunk_parser uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  // header model state
  walk_t       w_phase;
  logic [3:0]  w_cnt;
  logic [31:0] w_shift;
  logic [31:0] w_tag;
  logic [31:0] w_len;
  logic [31:0] w_skip;
  logic [31:0] w_pos;
  logic [15:0] w_chans;
  logic [31:0] w_rate;
  logic [15:0] w_bits;
  logic        w_done;
  logic        w_magic_bad;

  result_t     verdicts_due[$];
  logic [7:0]  wav_bytes[$];
  int          mismatch_count = 0;
  int          bytes_sent = 0;
  int          src_idle_pct;
  int          sink_idle_pct;
  int          hold_request;
  int          hold_left = 0;

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------- model

  function automatic void clear_walk();
    w_phase     = W_RIFF;
    w_cnt       = '0;
    w_shift     = '0;
    w_tag       = '0;
    w_len       = '0;
    w_skip      = '0;
    w_pos       = '0;
    w_chans     = '0;
    w_rate      = '0;
    w_bits      = '0;
    w_done      = 1'b0;
    w_magic_bad = 1'b0;
  endfunction

  // counts one byte of a 32-bit field, true once the field is complete
  function automatic bit word_full();
    w_cnt = w_cnt + 4'd1;
    if (w_cnt >= 4'd4) begin
      w_cnt = '0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic result_t verdict(status_t s, bit with_data);
    result_t r;
    r.status      = s;
    r.channels    = w_chans;
    r.sample_rate = w_rate;
    r.data_size   = with_data ? w_len : 32'd0;
    r.data_offset = with_data ? w_pos : 32'd0;
    return r;
  endfunction

  // advances the walk by one byte; true when the byte yields a verdict
  function automatic bit parse_byte(input logic [7:0] b, input logic eos,
                                    output result_t r);
    bit         hit;
    logic [3:0] idx;
    hit = 1'b0;
    r   = '0;
    // swallow bytes after a verdict, rearm on the final one
    if (w_done) begin
      if (eos) clear_walk();
      return 1'b0;
    end
    w_pos   = w_pos + 32'd1;
    w_shift = {b, w_shift[31:8]};
    case (w_phase)
      W_RIFF: begin
        if (word_full()) begin
          w_magic_bad = (w_shift != TAG_RIFF);
          w_phase     = W_RSIZE;
        end
      end
      W_RSIZE: begin
        if (word_full()) w_phase = W_WAVE;
      end
      W_WAVE: begin
        if (word_full()) begin
          if (w_magic_bad || w_shift != TAG_WAVE) begin
            hit = 1'b1;
            r   = verdict(STAT_BAD_MAGIC, 1'b0);
          end else begin
            w_phase = W_ID;
          end
        end
      end
      W_ID: begin
        if (word_full()) begin
          w_tag   = w_shift;
          w_phase = W_SIZE;
        end
      end
      W_SIZE: begin
        if (word_full()) begin
          w_len = w_shift;
          if (w_tag == TAG_FMT) begin
            w_phase = W_FMT;
          end else if (w_tag == TAG_DATA) begin
            hit = 1'b1;
            r   = verdict((w_chans != 0 && w_rate != 0 && w_len != 0 &&
                           w_bits == BITS_REQUIRED) ? STAT_OK : STAT_BAD_PARAMS,
                          1'b1);
          end else begin
            // padded skip, wraps at 32 bits
            w_skip  = (w_len + 32'd1) & ~32'd1;
            w_phase = (w_skip != 0) ? W_SKIP : W_ID;
          end
        end
      end
      W_FMT: begin
        idx   = w_cnt;
        w_cnt = w_cnt + 4'd1;
        if (idx == 4'd1) begin
          if (w_shift[31:16] != PCM_FORMAT) begin
            hit = 1'b1;
            r   = verdict(STAT_NOT_PCM, 1'b0);
          end
        end else if (idx == 4'd3) begin
          w_chans = w_shift[31:16];
        end else if (idx == 4'd7) begin
          w_rate = w_shift;
        end else if (idx == 4'd15) begin
          w_bits  = w_shift[31:16];
          w_cnt   = '0;
          w_skip  = (w_len > FMT_BODY) ? w_len - FMT_BODY : 32'd0;
          w_phase = (w_skip != 0) ? W_SKIP : W_ID;
        end
      end
      W_SKIP: begin
        w_skip = w_skip - 32'd1;
        if (w_skip == 0) begin
          w_cnt   = '0;
          w_phase = W_ID;
        end
      end
      default: begin
        w_phase = W_RIFF;
        w_cnt   = '0;
      end
    endcase
    // early end, unless the same byte already gave a verdict
    if (!hit && eos) begin
      hit = 1'b1;
      r   = verdict(STAT_TRUNCATED, 1'b0);
    end
    if (eos) clear_walk();
    else if (hit) w_done = 1'b1;
    return hit;
  endfunction

  // ------------------------------------------------------------- checking

  function automatic void check_field(string name, logic [31:0] want,
                                      logic [31:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0h, got %0h", name, want, got);
      mismatch_count++;
    end
  endfunction

  // compare verdict items, then predict from accepted bytes
  always @(posedge clk) begin : verdict_check
    result_t want;
    result_t fresh;
    if (!rst_n) begin
      clear_walk();
    end else begin
      if (out_chan.valid && out_chan.ready) begin
        if (verdicts_due.size() == 0) begin
          $error("verdict item with none pending: status %0d", out_chan.status);
          mismatch_count++;
        end else begin
          want = verdicts_due.pop_front();
          check_field("status", 32'(want.status), 32'(out_chan.status));
          check_field("channels", 32'(want.channels), 32'(out_chan.channels));
          check_field("sample_rate", want.sample_rate, out_chan.sample_rate);
          check_field("data_size", want.data_size, out_chan.data_size);
          check_field("data_offset", want.data_offset, out_chan.data_offset);
        end
      end
      if (in_chan.valid && in_chan.ready) begin
        if (parse_byte(in_chan.stream_byte, in_chan.end_of_stream, fresh))
          verdicts_due.push_back(fresh);
      end
    end
  end

  // receiver: random stalls, or a long hold when one is requested
  always @(negedge clk) begin
    if (hold_request != 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left != 0) begin
      out_chan.ready = 1'b0;
      hold_left--;
    end else begin
      out_chan.ready = ($urandom_range(99) >= sink_idle_pct);
    end
  end

  // watchdog on cycles with no item moving on either side
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready))
        quiet = 0;
      else
        quiet++;
    end
    $error("no item moved for %0d cycles", STALL_LIMIT);
    $display("[wav_header_chunk_parser] ERROR");
    $finish;
  end

  // ------------------------------------------------------- file building

  function automatic void put_u16(logic [15:0] v);
    wav_bytes.push_back(v[7:0]);
    wav_bytes.push_back(v[15:8]);
  endfunction

  function automatic void put_u32(logic [31:0] v);
    put_u16(v[15:0]);
    put_u16(v[31:16]);
  endfunction

  function automatic void put_riff_wave(logic [31:0] riff, logic [31:0] wave);
    put_u32(riff);
    put_u32($urandom);
    put_u32(wave);
  endfunction

  function automatic void put_chunk(logic [31:0] tag, logic [31:0] size, int body);
    put_u32(tag);
    put_u32(size);
    repeat (body) wav_bytes.push_back(8'($urandom));
  endfunction

  function automatic void put_fmt(logic [31:0] size, logic [15:0] code,
                                  logic [15:0] ch, logic [31:0] rate,
                                  logic [15:0] bits);
    put_u32(TAG_FMT);
    put_u32(size);
    put_u16(code);
    put_u16(ch);
    put_u32(rate);
    put_u32($urandom);
    put_u16(16'($urandom));
    put_u16(bits);
    if (size > FMT_BODY) repeat (size - FMT_BODY) wav_bytes.push_back(8'($urandom));
  endfunction

  function automatic void put_data(logic [31:0] size, int trail);
    put_u32(TAG_DATA);
    put_u32(size);
    repeat (trail) wav_bytes.push_back(8'($urandom));
  endfunction

  function automatic void put_wav(logic [15:0] code, logic [15:0] ch,
                                  logic [31:0] rate, logic [15:0] bits,
                                  logic [31:0] dsize, int trail);
    put_riff_wave(TAG_RIFF, TAG_WAVE);
    put_fmt(FMT_BODY, code, ch, rate, bits);
    put_data(dsize, trail);
  endfunction

  function automatic logic [31:0] other_tag();
    logic [31:0] t;
    do t = $urandom; while (t == TAG_FMT || t == TAG_DATA);
    return t;
  endfunction

  // ------------------------------------------------------------- sending

  task automatic send_item(input logic [7:0] b, input logic eos);
    while ($urandom_range(99) < src_idle_pct) begin
      in_chan.valid = 1'b0;
      @(negedge clk);
    end
    in_chan.valid         = 1'b1;
    in_chan.stream_byte   = b;
    in_chan.end_of_stream = eos;
    do @(posedge clk); while (!in_chan.ready);
    @(negedge clk);
    bytes_sent++;
  endtask

  // sends the built file with end_of_stream on its last byte
  task automatic send_file();
    int n;
    n = wav_bytes.size();
    for (int i = 0; i < n; i++) send_item(wav_bytes[i], i == n - 1);
    in_chan.valid = 1'b0;
    wav_bytes.delete();
  endtask

  task automatic wait_drain();
    while (verdicts_due.size() != 0) @(negedge clk);
  endtask

  // ---------------------------------------------------------------- tests

  task automatic test_valid_header();
    // verdict on the final byte, then with bytes trailing
    put_wav(PCM_FORMAT, 16'd2, 32'd44100, BITS_REQUIRED, 32'd1000, 0);
    send_file();
    put_wav(PCM_FORMAT, 16'hFFFF, 32'hFFFF_FFFF, BITS_REQUIRED, 32'hFFFF_FFFF, 4);
    send_file();
  endtask

  task automatic test_bad_magic();
    // wrong RIFF tag, wrong WAVE tag, verdict on the final byte
    put_riff_wave(32'h5846_4952, TAG_WAVE);
    repeat (5) wav_bytes.push_back(8'($urandom));
    send_file();
    put_riff_wave(TAG_RIFF, 32'h0000_0000);
    send_file();
    // stream ends before the tags are judged
    put_u32(32'h5846_4952);
    repeat (3) wav_bytes.push_back(8'hFF);
    send_file();
  endtask

  task automatic test_not_pcm();
    put_wav(16'd3, 16'd2, 32'd48000, BITS_REQUIRED, 32'd64, 3);
    send_file();
    put_wav(16'hFFFF, 16'd1, 32'd8000, BITS_REQUIRED, 32'd64, 0);
    send_file();
  endtask

  task automatic test_bad_params();
    put_wav(PCM_FORMAT, 16'd0, 32'd44100, BITS_REQUIRED, 32'd10, 1);
    send_file();
    put_wav(PCM_FORMAT, 16'd1, 32'd0, BITS_REQUIRED, 32'd10, 1);
    send_file();
    put_wav(PCM_FORMAT, 16'd1, 32'd8000, BITS_REQUIRED, 32'd0, 1);
    send_file();
    put_wav(PCM_FORMAT, 16'd1, 32'd8000, 16'd8, 32'd10, 1);
    send_file();
  endtask

  task automatic test_chunk_skipping();
    // odd-size chunk with pad, size that wraps to no skip, long fmt chunk
    put_riff_wave(TAG_RIFF, TAG_WAVE);
    put_chunk(other_tag(), 32'd5, 6);
    put_chunk(other_tag(), 32'hFFFF_FFFF, 0);
    put_fmt(32'd19, PCM_FORMAT, 16'd2, 32'd22050, BITS_REQUIRED);
    put_data(32'd4, 2);
    send_file();
    // short fmt chunk still takes 16 bytes, second fmt chunk overrides
    put_riff_wave(TAG_RIFF, TAG_WAVE);
    put_fmt(32'd12, PCM_FORMAT, 16'd0, 32'd0, 16'd8);
    put_chunk(other_tag(), 32'd0, 0);
    put_fmt(FMT_BODY, PCM_FORMAT, 16'd6, 32'd96000, BITS_REQUIRED);
    put_data(32'd128, 0);
    send_file();
  endtask

  task automatic test_truncation();
    // ends inside the fmt body and inside a skipped chunk
    put_wav(PCM_FORMAT, 16'd2, 32'd44100, BITS_REQUIRED, 32'd1000, 0);
    while (wav_bytes.size() > 27) void'(wav_bytes.pop_back());
    send_file();
    put_riff_wave(TAG_RIFF, TAG_WAVE);
    put_chunk(other_tag(), 32'd9, 4);
    send_file();
  endtask

  task automatic test_receiver_hold();
    // receiver holds off while several short files with verdicts arrive
    hold_request = HOLD_CYCLES;
    repeat (4) begin
      put_riff_wave(TAG_RIFF, other_tag());
      send_file();
    end
    wait_drain();
  endtask

  task automatic test_random_stream(int target);
    int          first;
    int          kind;
    int          n;
    int          pick;
    logic [31:0] fmt_len;
    logic [31:0] csize;
    logic [15:0] code;
    logic [15:0] ch;
    logic [31:0] rate;
    logic [15:0] bits;
    logic [31:0] dsize;
    first = bytes_sent;
    while (bytes_sent - first < target) begin
      kind = $urandom_range(99);
      if (kind < 12) begin
        // noise, sometimes behind a good RIFF tag
        if ($urandom_range(1) == 0) put_u32(TAG_RIFF);
        repeat ($urandom_range(1, 20)) wav_bytes.push_back(8'($urandom));
      end else begin
        put_riff_wave(TAG_RIFF, TAG_WAVE);
        repeat ($urandom_range(0, 2)) begin
          csize = $urandom_range(0, 9);
          put_chunk(other_tag(), csize, (csize + 1) & ~32'd1);
        end
        code = ($urandom_range(19) == 0) ? 16'($urandom) : PCM_FORMAT;
        pick = $urandom_range(99);
        ch   = (pick < 8) ? 16'd0 : (pick < 12) ? 16'hFFFF : 16'($urandom_range(1, 8));
        pick = $urandom_range(99);
        rate = (pick < 8) ? 32'd0 : (pick < 25) ? 32'($urandom) :
               (pick < 60) ? 32'd44100 : 32'd48000;
        bits = ($urandom_range(4) == 0) ? 16'($urandom) : BITS_REQUIRED;
        fmt_len = ($urandom_range(3) == 0) ? 32'($urandom_range(0, 22)) : FMT_BODY;
        put_fmt(fmt_len, code, ch, rate, bits);
        if ($urandom_range(9) == 0) begin
          csize = $urandom_range(0, 5);
          put_chunk(other_tag(), csize, (csize + 1) & ~32'd1);
        end
        dsize = ($urandom_range(9) == 0) ? 32'd0 : 32'($urandom);
        put_data(dsize, $urandom_range(0, 4));
        n = wav_bytes.size();
        if (kind < 22) begin
          // single flipped bit anywhere in the file
          pick = $urandom_range(0, n - 1);
          wav_bytes[pick] = wav_bytes[pick] ^ (8'd1 << $urandom_range(7));
        end else if (kind < 40) begin
          pick = $urandom_range(1, n - 1);
          while (wav_bytes.size() > pick) void'(wav_bytes.pop_back());
        end
      end
      send_file();
    end
  endtask

  // ----------------------------------------------------------------- main

  initial begin
    rst_n                 = 1'b0;
    in_chan.valid         = 1'b0;
    in_chan.stream_byte   = '0;
    in_chan.end_of_stream = 1'b0;
    out_chan.ready        = 1'b0;
    hold_request          = 0;
    src_idle_pct          = 38;
    sink_idle_pct         = 53;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_valid_header();
    test_bad_magic();
    test_not_pcm();
    test_bad_params();
    test_chunk_skipping();
    test_truncation();
    test_receiver_hold();
    test_random_stream(320);
    wait_drain();

    src_idle_pct  = 53;
    sink_idle_pct = 38;
    test_random_stream(330);
    wait_drain();

    src_idle_pct  = 0;
    sink_idle_pct = 0;
    test_random_stream(330);
    wait_drain();

    // wait out anything the block might still send
    repeat (10) @(posedge clk);
    if (mismatch_count == 0 && verdicts_due.size() == 0) begin
      $display("[wav_header_chunk_parser] OK");
    end else begin
      if (verdicts_due.size() != 0)
        $error("%0d expected verdicts never arrived", verdicts_due.size());
      $display("[wav_header_chunk_parser] ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/whcp_pkg.sv
rtl/whcp_if.sv
rtl/whcp_in_stage.sv
rtl/whcp_parse.sv
rtl/wav_header_chunk_parser.sv
rtl/whcp_checker.sv
verif/tb.sv
